### sv/mdrf_pkg.sv
// Package for the multichannel datagram ring FIFO.
// Holds sizes, status and operation codes, beat structs and pointer helpers.
// No dependencies.
package mdrf_pkg;

    localparam int CHANNELS   = 4;
    localparam int DESC_DEPTH = 256;
    localparam int DATA_DEPTH = 4096;

    localparam int CH_W    = 2;
    localparam int DATA_AW = $clog2(DATA_DEPTH);
    localparam int DESC_AW = $clog2(DESC_DEPTH);
    localparam int CNT_W   = $clog2(DATA_DEPTH + 1);
    localparam int DG_W    = $clog2(DESC_DEPTH + 1);
    localparam int SMP_W   = 16;
    localparam int STAT_W  = 2;
    localparam int BYTES_W = 14;
    localparam int HELD_DG_W  = 9;
    localparam int HELD_SMP_W = 13;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    op;
        logic [CH_W-1:0]         chan;
        logic signed [SMP_W-1:0] sample;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [SMP_W-1:0] sample_out;
        logic                    datagram_end;
        logic [BYTES_W-1:0]      datagram_bytes;
        logic [HELD_DG_W-1:0]    datagrams_held;
        logic [HELD_SMP_W-1:0]   samples_held;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted beat
        logic resolve;  // push or reject, register result
        logic read;     // launch ring reads for a pull
        logic finish;   // retire the pulled sample, register result
    } t_cmd;

    typedef struct packed {
        logic pull_ok;
    } t_stat;

    function automatic logic [DATA_AW-1:0] data_next(input logic [DATA_AW-1:0] p);
        data_next = (p == DATA_AW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DESC_AW-1:0] desc_next(input logic [DESC_AW-1:0] p);
        desc_next = (p == DESC_AW'(DESC_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### sv/multichannel_datagram_ring_fifo.sv
// Top level of the multichannel datagram ring FIFO.
// Joins controller mdrf_ctrl and datapath mdrf_dp. Uses mdrf_pkg.
//
// Four channels, each with a 4096-sample ring and a 256-entry datagram
// length ring. Issue a beat by raising start while busy is low: op 0 pushes
// one sample (last commits the open datagram), op 1 pulls the oldest
// committed sample. Exactly one result beat follows each accepted beat, shown
// for a single cycle with o_strobe high; the receiver cannot stall it, so
// capture it on that cycle. A push or any rejected beat passes from accept
// through a check state to the strobe; a successful pull passes a further
// fetch state, for the registered read port of the sample and length rings.
// busy drops in the strobe cycle, so the next beat may be accepted while the
// result is shown. Sample and length entries hold no reset value; only
// committed entries are ever read.
// Samples of an open datagram are never returned by a pull.
module multichannel_datagram_ring_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  mdrf_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_strobe,
    output mdrf_pkg::t_out_item o_result
);
    import mdrf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence each beat
    mdrf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // rings, pointers, counts and result register
    mdrf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

### sv/mdrf_ctrl.sv
// Controller for the multichannel datagram ring FIFO.
// Sequences accept, check, ring fetch and result strobe. Uses mdrf_pkg.
module mdrf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mdrf_pkg::t_stat i_stat,
    output mdrf_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_strobe
);
    import mdrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && !r_busy) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (i_stat.pull_ok) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end
                end
                S_FETCH: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_start && !r_busy;
        o_cmd.resolve = (r_state == S_CHECK) && !i_stat.pull_ok;
        o_cmd.read    = (r_state == S_CHECK) && i_stat.pull_ok;
        o_cmd.finish  = (r_state == S_FETCH);
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

### sv/mdrf_dp.sv
// Datapath for the multichannel datagram ring FIFO.
// Holds the sample and length rings, per-channel pointers and counts. Uses mdrf_pkg.
module mdrf_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdrf_pkg::t_in_item  i_item,
    input  mdrf_pkg::t_cmd      i_cmd,
    output mdrf_pkg::t_stat     o_stat,
    output mdrf_pkg::t_out_item o_result
);
    import mdrf_pkg::*;

    // ring storage, one region per channel
    logic [SMP_W-1:0] r_sample_mem [CHANNELS*DATA_DEPTH];
    logic [CNT_W-1:0] r_length_mem [CHANNELS*DESC_DEPTH];
    logic [SMP_W-1:0] r_rd_sample;
    logic [CNT_W-1:0] r_rd_len;

    logic [DATA_AW-1:0] r_swp  [CHANNELS];
    logic [DATA_AW-1:0] r_srp  [CHANNELS];
    logic [DESC_AW-1:0] r_lwp  [CHANNELS];
    logic [DESC_AW-1:0] r_lrp  [CHANNELS];
    logic [CNT_W-1:0]   r_cs   [CHANNELS];
    logic [DG_W-1:0]    r_cdg  [CHANNELS];
    logic [CNT_W-1:0]   r_open [CHANNELS];
    logic [CNT_W-1:0]   r_rpos [CHANNELS];

    t_in_item  r_item;
    t_out_item r_res;
    t_out_item n_res;

    logic [CH_W-1:0]  ch;
    logic             in_range;
    logic             data_full;
    logic             desc_full;
    logic             push_ok;
    logic [CNT_W-1:0] open_inc;
    logic [CNT_W-1:0] rpos_inc;
    logic             dg_end;
    logic [DG_W-1:0]  n_cdg;
    logic [CNT_W-1:0] n_cs;

    assign ch       = r_item.chan;
    assign in_range = (32'(r_item.chan) < CHANNELS);

    always_comb begin
        data_full = ({1'b0, r_cs[ch]} + {1'b0, r_open[ch]}) >= (CNT_W+1)'(DATA_DEPTH);
        desc_full = r_item.last && (r_cdg[ch] >= DG_W'(DESC_DEPTH));
        push_ok   = in_range && (r_item.op == OP_PUSH) && !data_full && !desc_full;
        o_stat.pull_ok = in_range && (r_item.op == OP_PULL)
                         && (r_cdg[ch] != '0) && (r_cs[ch] != '0);
        open_inc  = r_open[ch] + 1'b1;
        rpos_inc  = r_rpos[ch] + 1'b1;
        dg_end    = (rpos_inc >= r_rd_len);
    end

    // next result and counts
    always_comb begin
        n_res = '0;
        n_cdg = r_cdg[ch];
        n_cs  = r_cs[ch];
        if (i_cmd.finish) begin
            n_cdg = r_cdg[ch] - DG_W'(dg_end);
            n_cs  = r_cs[ch] - 1'b1;
            n_res.status         = ST_OK;
            n_res.sample_out     = r_rd_sample;
            n_res.datagram_end   = dg_end;
            n_res.datagram_bytes = dg_end ? {r_rd_len, 1'b0} : '0;
        end else begin
            if (push_ok && r_item.last) begin
                n_cdg = r_cdg[ch] + 1'b1;
                n_cs  = r_cs[ch] + open_inc;
            end
            if (push_ok) begin
                n_res.status = ST_OK;
            end else if (r_item.op == OP_PUSH) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.status = ST_EMPTY;
            end
        end
        if (in_range) begin
            n_res.datagrams_held = HELD_DG_W'(n_cdg);
            n_res.samples_held   = HELD_SMP_W'(n_cs);
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && push_ok) begin
            r_sample_mem[{ch, r_swp[ch]}] <= r_item.sample;
            if (r_item.last) begin
                r_length_mem[{ch, r_lwp[ch]}] <= open_inc;
            end
        end
        if (i_cmd.read) begin
            r_rd_sample <= r_sample_mem[{ch, r_srp[ch]}];
            r_rd_len    <= r_length_mem[{ch, r_lrp[ch]}];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.resolve || i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    // per-channel control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_swp[i]  <= '0;
                r_srp[i]  <= '0;
                r_lwp[i]  <= '0;
                r_lrp[i]  <= '0;
                r_cs[i]   <= '0;
                r_cdg[i]  <= '0;
                r_open[i] <= '0;
                r_rpos[i] <= '0;
            end
        end else if (i_cmd.resolve && push_ok) begin
            r_swp[ch] <= data_next(r_swp[ch]);
            r_cs[ch]  <= n_cs;
            r_cdg[ch] <= n_cdg;
            if (r_item.last) begin
                r_lwp[ch]  <= desc_next(r_lwp[ch]);
                r_open[ch] <= '0;
            end else begin
                r_open[ch] <= open_inc;
            end
        end else if (i_cmd.finish) begin
            r_srp[ch] <= data_next(r_srp[ch]);
            r_cs[ch]  <= n_cs;
            r_cdg[ch] <= n_cdg;
            if (dg_end) begin
                r_lrp[ch]  <= desc_next(r_lrp[ch]);
                r_rpos[ch] <= '0;
            end else begin
                r_rpos[ch] <= rpos_inc;
            end
        end
    end

    assign o_result = r_res;

endmodule

### verif/multichannel_datagram_ring_fifo_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for multichannel_datagram_ring_fifo: drives push and pull beats
// and compares every result strobe against a mirror of the per-channel rings.
// Depends on mdrf_pkg for sizes, codes and the beat structs.
module multichannel_datagram_ring_fifo_tb;
    import mdrf_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BEATS = 1314;
    localparam int MAX_REPORTS  = 10;

    // Mirror of the rings: a push or pull beat is noted at acceptance, its
    // result predicted at once and queued until the strobe shows it.
    class ring_mirror;
        logic [SMP_W-1:0] samples [CHANNELS][DATA_DEPTH];
        int unsigned      lengths [CHANNELS][DESC_DEPTH];
        int unsigned      smp_wr [CHANNELS];
        int unsigned      smp_rd [CHANNELS];
        int unsigned      len_wr [CHANNELS];
        int unsigned      len_rd [CHANNELS];
        int unsigned      held_smp [CHANNELS];
        int unsigned      held_dg [CHANNELS];
        int unsigned      open_len [CHANNELS];
        int unsigned      read_pos [CHANNELS];
        t_out_item        awaited_results [$];
        int               failures;
        int               mismatches;
        int               beats;
        int               full_rejects;
        int               empty_pulls;
        int               datagrams_out;

        function new();
            for (int c = 0; c < CHANNELS; c++) begin
                smp_wr[c] = 0; smp_rd[c] = 0; len_wr[c] = 0; len_rd[c] = 0;
                held_smp[c] = 0; held_dg[c] = 0; open_len[c] = 0; read_pos[c] = 0;
            end
            failures = 0; mismatches = 0; beats = 0;
            full_rejects = 0; empty_pulls = 0; datagrams_out = 0;
        endfunction

        // Advance the mirror by one accepted beat and return what the block owes.
        function t_out_item ring_step(t_in_item it);
            t_out_item   r;
            int unsigned ch;
            int unsigned len;
            r  = '0;
            ch = it.chan;
            if (ch >= CHANNELS) begin
                r.status = (it.op == OP_PUSH) ? ST_FULL : ST_EMPTY;
                return r;
            end
            if (it.op == OP_PUSH) begin
                // Reject on a full sample ring, or on a commit into a full length ring
                if (held_smp[ch] + open_len[ch] >= DATA_DEPTH ||
                    (it.last && held_dg[ch] >= DESC_DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    samples[ch][smp_wr[ch]] = it.sample;
                    smp_wr[ch] = (smp_wr[ch] + 1) % DATA_DEPTH;
                    open_len[ch]++;
                    if (it.last) begin
                        lengths[ch][len_wr[ch]] = open_len[ch];
                        len_wr[ch] = (len_wr[ch] + 1) % DESC_DEPTH;
                        held_smp[ch] += open_len[ch];
                        held_dg[ch]++;
                        open_len[ch] = 0;
                    end
                end
            end else begin
                if (held_dg[ch] == 0 || held_smp[ch] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    len          = lengths[ch][len_rd[ch]];
                    r.sample_out = samples[ch][smp_rd[ch]];
                    smp_rd[ch]   = (smp_rd[ch] + 1) % DATA_DEPTH;
                    held_smp[ch]--;
                    read_pos[ch]++;
                    if (read_pos[ch] >= len) begin
                        r.datagram_end   = 1'b1;
                        r.datagram_bytes = BYTES_W'(len * 2);
                        len_rd[ch]       = (len_rd[ch] + 1) % DESC_DEPTH;
                        held_dg[ch]--;
                        read_pos[ch]     = 0;
                    end
                end
            end
            r.datagrams_held = HELD_DG_W'(held_dg[ch]);
            r.samples_held   = HELD_SMP_W'(held_smp[ch]);
            return r;
        endfunction

        function void note_beat(t_in_item it);
            t_out_item r;
            r = ring_step(it);
            beats++;
            if (r.status == ST_FULL) full_rejects++;
            if (r.status == ST_EMPTY) empty_pulls++;
            if (r.datagram_end) datagrams_out++;
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (awaited_results.size() == 0) begin
                failures++;
                $display("ERROR: result strobe with nothing awaited: %p", got);
                return;
            end
            exp_r = awaited_results.pop_front();
            if (got.status !== exp_r.status || got.sample_out !== exp_r.sample_out ||
                got.datagram_end !== exp_r.datagram_end ||
                got.datagram_bytes !== exp_r.datagram_bytes ||
                got.datagrams_held !== exp_r.datagrams_held ||
                got.samples_held !== exp_r.samples_held) begin
                failures++;
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: mismatch at %0t", $realtime);
                    $display("  status   exp %0d got %0d", exp_r.status, got.status);
                    $display("  sample   exp %h got %h", exp_r.sample_out, got.sample_out);
                    $display("  end      exp %b got %b", exp_r.datagram_end, got.datagram_end);
                    $display("  bytes    exp %0d got %0d",
                             exp_r.datagram_bytes, got.datagram_bytes);
                    $display("  dg held  exp %0d got %0d",
                             exp_r.datagrams_held, got.datagrams_held);
                    $display("  smp held exp %0d got %0d",
                             exp_r.samples_held, got.samples_held);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    ring_mirror  board;
    int          burst_left;
    int          cycle_count = 0;
    int unsigned dg_left [CHANNELS];

    multichannel_datagram_ring_fifo DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up on a hung block; the limit sits well above the slowest clean run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached");
            $display("multichannel_datagram_ring_fifo_tb: done, errors");
            $finish;
        end
    end

    // Results cannot be held off, so take every strobe on the edge that ends it.
    always @(posedge i_clk) begin
        if (o_strobe === 1'b1) begin
            board.check_result(o_result);
        end
    end

    function automatic t_in_item make_beat(logic op, int ch, logic [SMP_W-1:0] smp, logic last);
        t_in_item it;
        it.op     = op;
        it.chan   = CH_W'(ch);
        it.sample = smp;
        it.last   = last;
        return it;
    endfunction

    // Present one beat and hold it until accepted. Between bursts drop start
    // for a random gap so that idle cycles land on every phase of the block.
    task automatic send_beat(input t_in_item it);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_beat(it);
    endtask

    task automatic push(input int ch, input logic [SMP_W-1:0] smp, input logic last);
        send_beat(make_beat(OP_PUSH, ch, smp, last));
    endtask

    task automatic pull(input int ch);
        send_beat(make_beat(OP_PULL, ch, SMP_W'($urandom), 1'($urandom)));
    endtask

    // Well-formed datagrams with random content on random channels, mixed with
    // pulls, mostly short, some longer, with a little noise on the last flag.
    task automatic random_traffic(input int n);
        int  ch;
        logic last;
        for (int k = 0; k < n; k++) begin
            ch = $urandom_range(0, CHANNELS - 1);
            if ($urandom_range(0, 99) < 55) begin
                if (dg_left[ch] == 0) begin
                    dg_left[ch] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48)
                                                             : $urandom_range(1, 8);
                end
                dg_left[ch]--;
                last = (dg_left[ch] == 0);
                if ($urandom_range(0, 99) < 3) begin
                    last = 1'($urandom);
                    if (last) dg_left[ch] = 0;
                end
                push(ch, SMP_W'($urandom), last);
            end else begin
                pull(ch);
            end
        end
    endtask

    initial begin
        board       = new();
        burst_left  = 0;
        for (int c = 0; c < CHANNELS; c++) dg_left[c] = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pulls, open datagram not visible, sample extremes
        pull(0);
        push(0, 16'h8000, 1'b0);
        pull(0);
        push(0, 16'h7FFF, 1'b1);
        pull(0);
        pull(0);
        pull(0);
        push(1, 16'hFFFF, 1'b1);
        push(1, 16'h0000, 1'b1);
        push(2, 16'h5555, 1'b0);
        push(2, 16'hAAAA, 1'b1);
        push(3, 16'h0001, 1'b1);
        pull(1);
        pull(2);
        pull(1);
        pull(2);
        pull(3);
        pull(3);

        // Length ring full on channel 3: fill with single-sample datagrams,
        // reject a further commit, keep an open sample, drain and wrap.
        for (int k = 0; k < DESC_DEPTH; k++) push(3, SMP_W'($urandom), 1'b1);
        push(3, SMP_W'($urandom), 1'b1);
        push(3, SMP_W'($urandom), 1'b0);
        for (int k = 0; k < DESC_DEPTH; k++) pull(3);
        pull(3);
        push(3, SMP_W'($urandom), 1'b1);
        pull(3);
        pull(3);

        random_traffic(RANDOM_BEATS);

        // Drain: wait for every awaited result, then a few cycles for strays.
        start <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (board.awaited_results.size() != 0) board.failures++;
        $display("Run covered %0d beats: %0d full rejects, %0d empty pulls, %0d datagrams out",
                 board.beats, board.full_rejects, board.empty_pulls, board.datagrams_out);
        $display("Mismatches seen: %0d", board.mismatches);
        if (board.failures == 0) begin
            $display("multichannel_datagram_ring_fifo_tb: done, clean");
        end else begin
            $display("multichannel_datagram_ring_fifo_tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
sv/mdrf_pkg.sv
sv/mdrf_ctrl.sv
sv/mdrf_dp.sv
sv/multichannel_datagram_ring_fifo.sv
verif/multichannel_datagram_ring_fifo_tb.sv
